// ===== sv/decimating_iir_filter_with_threshold_unit_macros.svh =====
// Assertion macros shared by the filter modules.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef DECIMATING_IIR_FILTER_WITH_THRESHOLD_UNIT_MACROS_SVH
`define DECIMATING_IIR_FILTER_WITH_THRESHOLD_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DIFT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DIFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dift_pkg.sv =====
// Shared widths, register indexes, reset values and types of the filter unit.
// No dependencies.
package dift_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FACTOR_W   = 7;
  localparam int unsigned GAIN_W     = 28;
  localparam int unsigned GAIN_FRAC  = 20;
  localparam int unsigned COEF_W     = 25;
  localparam int unsigned COEF_FRAC  = 22;
  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned HIST_W     = 48;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 28;

  localparam int unsigned DEF_MAX_DECIMATION    = 64;
  localparam int unsigned DEF_HISTORY_FRAC_BITS = 16;

  localparam logic [MAG_W-1:0] OUT_MAG_MAX = 15'h7FFF;

  localparam logic                       RST_FILTER_MODE = 1'b0;
  localparam logic [FACTOR_W-1:0]        RST_DECIMATION  = 7'd1;
  localparam logic [GAIN_W-1:0]          RST_GAIN        = 28'd1048576;
  localparam logic signed [COEF_W-1:0]   RST_COEF        = '0;
  localparam logic [THRESH_W-1:0]        RST_THRESHOLD   = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE         = 3'd0,
    REG_DECIMATION_FACTOR   = 3'd1,
    REG_INPUT_GAIN          = 3'd2,
    REG_COEF_A              = 3'd3,
    REG_COEF_B              = 3'd4,
    REG_AMPLITUDE_THRESHOLD = 3'd5
  } dift_reg_e;

  typedef struct packed {
    logic clr_hist;
    logic clr_flag;
  } dift_ctl_t;

endpackage

// ===== sv/dift_if.sv =====
// Valid/ready channel interfaces for the filter unit's input and result streams.
// Depends on dift_pkg for the payload widths.
interface dift_in_if import dift_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       buffer_start;
  logic                       clear_history;

  modport source (output valid, sample_in, buffer_start, clear_history, input ready);
  modport sink (input valid, sample_in, buffer_start, clear_history, output ready);
endinterface

interface dift_out_if import dift_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       threshold_exceeded;

  modport source (output valid, sample_out, threshold_exceeded, input ready);
  modport sink (input valid, sample_out, threshold_exceeded, output ready);
endinterface

// ===== sv/decimating_iir_filter_with_threshold_unit.sv =====
// Top level of the decimating IIR filter: configuration registers and the four-stage pipeline.
// Depends on dift_pkg, dift_if and the dift_decim, dift_gain, dift_iir, dift_out modules.
//
//   Channel   Direction  Payload                                      Transaction
//   in_i      sink       sample_in, buffer_start, clear_history       valid && ready
//   out_o     source     sample_out, threshold_exceeded               valid && ready
//   cfg       write      cfg_idx_i, cfg_data_i                        cfg_we_i
//
// One input transaction can be taken every cycle while out_o is not stalled; a finished group
// is registered by the decimation, gain, filter and output stages in turn on its way to out_o.
// The rate is set by the filter stage, whose history feedback closes within that stage.
// Every stage holds while the stage after it is full, and empty stages still accept.
// Reset is asynchronous; no clearing pass is needed after it.

module decimating_iir_filter_with_threshold_unit import dift_pkg::*; #(
  parameter int unsigned MAX_DECIMATION    = DEF_MAX_DECIMATION,
  parameter int unsigned HISTORY_FRAC_BITS = DEF_HISTORY_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dift_in_if.sink               in_i,
  dift_out_if.source            out_o
);

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(MAX_DECIMATION);

  logic                       filter_mode_q;
  logic [FACTOR_W-1:0]        factor_q;
  logic [GAIN_W-1:0]          gain_q;
  logic signed [COEF_W-1:0]   coef_a_q, coef_b_q;
  logic [THRESH_W-1:0]        threshold_q;

  logic                       s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;
  logic signed [SUM_W-1:0]    s1_sum;
  dift_ctl_t                  s1_ctl, s2_ctl;
  logic signed [HIST_W-1:0]   s2_x, s3_y;
  logic                       s3_clr_flag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q <= RST_FILTER_MODE;
      factor_q      <= RST_DECIMATION;
      gain_q        <= RST_GAIN;
      coef_a_q      <= RST_COEF;
      coef_b_q      <= RST_COEF;
      threshold_q   <= RST_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FILTER_MODE:         filter_mode_q <= cfg_data_i[0];
        REG_DECIMATION_FACTOR:   factor_q      <= cfg_data_i[FACTOR_W-1:0];
        REG_INPUT_GAIN:          gain_q        <= cfg_data_i[GAIN_W-1:0];
        REG_COEF_A:              coef_a_q      <= $signed(cfg_data_i[COEF_W-1:0]);
        REG_COEF_B:              coef_b_q      <= $signed(cfg_data_i[COEF_W-1:0]);
        REG_AMPLITUDE_THRESHOLD: threshold_q   <= cfg_data_i[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dift_decim #(
    .MAX_DECIMATION (MAX_DECIMATION)
  ) u_decim (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .factor_i        (factor_q),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .sample_i        (in_i.sample_in),
    .buffer_start_i  (in_i.buffer_start),
    .clear_history_i (in_i.clear_history),
    .s1_valid_o      (s1_valid),
    .s1_ready_i      (s1_ready),
    .s1_sum_o        (s1_sum),
    .s1_ctl_o        (s1_ctl)
  );

  dift_gain #(
    .MAX_DECIMATION    (MAX_DECIMATION),
    .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS)
  ) u_gain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gain_i     (gain_q),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_sum_i   (s1_sum),
    .s1_ctl_i   (s1_ctl),
    .s2_valid_o (s2_valid),
    .s2_ready_i (s2_ready),
    .s2_x_o     (s2_x),
    .s2_ctl_o   (s2_ctl)
  );

  dift_iir u_iir (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .filter_mode_i (filter_mode_q),
    .coef_a_i      (coef_a_q),
    .coef_b_i      (coef_b_q),
    .s2_valid_i    (s2_valid),
    .s2_ready_o    (s2_ready),
    .s2_x_i        (s2_x),
    .s2_ctl_i      (s2_ctl),
    .s3_valid_o    (s3_valid),
    .s3_ready_i    (s3_ready),
    .s3_y_o        (s3_y),
    .s3_clr_flag_o (s3_clr_flag)
  );

  dift_out #(
    .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS)
  ) u_out (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .threshold_i          (threshold_q),
    .s3_valid_i           (s3_valid),
    .s3_ready_o           (s3_ready),
    .s3_y_i               (s3_y),
    .s3_clr_flag_i        (s3_clr_flag),
    .out_valid_o          (out_o.valid),
    .out_ready_i          (out_o.ready),
    .sample_out_o         (out_o.sample_out),
    .threshold_exceeded_o (out_o.threshold_exceeded)
  );

endmodule

// ===== sv/dift_decim.sv =====
// Decimation stage: sums samples into groups and registers each finished group sum.
// Depends on dift_pkg and the assertion macro header.
`include "decimating_iir_filter_with_threshold_unit_macros.svh"

module dift_decim import dift_pkg::*; #(
  parameter int unsigned MAX_DECIMATION = DEF_MAX_DECIMATION
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [FACTOR_W-1:0]        factor_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       buffer_start_i,
  input  logic                       clear_history_i,
  output logic                       s1_valid_o,
  input  logic                       s1_ready_i,
  output logic signed [SAMPLE_W+$clog2(MAX_DECIMATION)-1:0] s1_sum_o,
  output dift_ctl_t                  s1_ctl_o
);

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(MAX_DECIMATION);
  localparam int unsigned CNT_W = $clog2(MAX_DECIMATION + 1);
  localparam int unsigned CMP_W = (CNT_W > FACTOR_W) ? CNT_W : FACTOR_W;
  localparam logic [CMP_W-1:0] MAX_D   = CMP_W'(MAX_DECIMATION);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DECIMATION);

  logic signed [SUM_W-1:0] sum_q, sum_d, sum_base;
  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_base;
  logic [CMP_W-1:0]        fac, fac_eff, cnt_inc;
  logic                    pend_flag_q, pend_flag_d, pend_hist_q, pend_hist_d;
  logic                    s1_valid_q, s1_valid_d;
  logic signed [SUM_W-1:0] s1_sum_q;
  dift_ctl_t               s1_ctl_q;
  logic                    acc, complete;

  always_comb begin
    fac = CMP_W'(factor_i);
    if (fac == '0) begin
      fac_eff = CMP_W'(1);
    end else if (fac > MAX_D) begin
      fac_eff = MAX_D;
    end else begin
      fac_eff = fac;
    end
  end

  assign sum_base   = buffer_start_i ? '0 : sum_q;
  assign cnt_base   = buffer_start_i ? '0 : cnt_q;
  assign cnt_inc    = CMP_W'(cnt_base) + CMP_W'(1);
  assign complete   = cnt_inc >= fac_eff;
  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    pend_flag_d = pend_flag_q;
    pend_hist_d = pend_hist_q;
    s1_valid_d  = s1_ready_i ? 1'b0 : s1_valid_q;
    if (acc) begin
      if (complete) begin
        sum_d       = '0;
        cnt_d       = '0;
        pend_flag_d = 1'b0;
        pend_hist_d = 1'b0;
        s1_valid_d  = 1'b1;
      end else begin
        sum_d       = sum_base + SUM_W'(sample_i);
        cnt_d       = cnt_inc[CNT_W-1:0];
        pend_flag_d = pend_flag_q || buffer_start_i;
        pend_hist_d = pend_hist_q || clear_history_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      pend_flag_q <= 1'b0;
      pend_hist_q <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      pend_flag_q <= pend_flag_d;
      pend_hist_q <= pend_hist_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && complete) begin
      s1_sum_q          <= sum_base + SUM_W'(sample_i);
      s1_ctl_q.clr_flag <= pend_flag_q || buffer_start_i;
      s1_ctl_q.clr_hist <= pend_hist_q || clear_history_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_sum_o   = s1_sum_q;
  assign s1_ctl_o   = s1_ctl_q;

  `DIFT_ASSERT_IMPL(a_cnt_below_max, clk_i, rst_ni, 1'b1, cnt_q < MAX_CNT, "group count out of range")
  `DIFT_ASSERT_NEXT(a_start_restarts, clk_i, rst_ni, acc && buffer_start_i && !complete, cnt_q == CNT_W'(1), "buffer start did not restart the group")
  `DIFT_ASSERT_NEXT(a_group_emits, clk_i, rst_ni, acc && complete, s1_valid_q && s1_ctl_q.clr_flag == $past(pend_flag_q || buffer_start_i), "finished group not registered")

endmodule

// ===== sv/dift_gain.sv =====
// Gain stage: scales the group sum by the unsigned Q8.20 gain into a saturated history value.
// Depends on dift_pkg.
module dift_gain import dift_pkg::*; #(
  parameter int unsigned MAX_DECIMATION    = DEF_MAX_DECIMATION,
  parameter int unsigned HISTORY_FRAC_BITS = DEF_HISTORY_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [GAIN_W-1:0]        gain_i,
  input  logic                     s1_valid_i,
  output logic                     s1_ready_o,
  input  logic signed [SAMPLE_W+$clog2(MAX_DECIMATION)-1:0] s1_sum_i,
  input  dift_ctl_t                s1_ctl_i,
  output logic                     s2_valid_o,
  input  logic                     s2_ready_i,
  output logic signed [HIST_W-1:0] s2_x_o,
  output dift_ctl_t                s2_ctl_o
);

  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(MAX_DECIMATION);
  localparam int unsigned PROD_W = SUM_W + GAIN_W + 1;
  localparam int unsigned R_SH   = (HISTORY_FRAC_BITS <= GAIN_FRAC) ?
                                   (GAIN_FRAC - HISTORY_FRAC_BITS) : 0;
  localparam int unsigned L_SH   = (HISTORY_FRAC_BITS > GAIN_FRAC) ?
                                   (HISTORY_FRAC_BITS - GAIN_FRAC) : 0;
  localparam int unsigned RAW_W  = PROD_W + L_SH;
  localparam int unsigned EXT_W  = (RAW_W > HIST_W) ? RAW_W : (HIST_W + 1);
  localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

  logic signed [PROD_W-1:0]    prod;
  logic signed [EXT_W-1:0]     scaled;
  logic [EXT_W-HIST_W:0]       top;
  logic signed [HIST_W-1:0]    x;
  logic                        s2_valid_q, adv;
  logic signed [HIST_W-1:0]    s2_x_q;
  dift_ctl_t                   s2_ctl_q;

  assign prod   = $signed(s1_sum_i) * $signed({1'b0, gain_i});
  assign scaled = (EXT_W'(prod) >>> R_SH) <<< L_SH;
  assign top    = scaled[EXT_W-1:HIST_W-1];

  always_comb begin
    if ((&top) || !(|top)) begin
      x = scaled[HIST_W-1:0];
    end else if (scaled[EXT_W-1]) begin
      x = HIST_MIN;
    end else begin
      x = HIST_MAX;
    end
  end

  assign s1_ready_o = !s2_valid_q || s2_ready_i;
  assign adv        = s1_valid_i && s1_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_x_q   <= x;
      s2_ctl_q <= s1_ctl_i;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_x_o     = s2_x_q;
  assign s2_ctl_o   = s2_ctl_q;

endmodule

// ===== sv/dift_iir.sv =====
// Recursive filter stage: holds the input and output histories and forms one new output.
// Depends on dift_pkg and the assertion macro header.
`include "decimating_iir_filter_with_threshold_unit_macros.svh"

module dift_iir import dift_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     filter_mode_i,
  input  logic signed [COEF_W-1:0] coef_a_i,
  input  logic signed [COEF_W-1:0] coef_b_i,
  input  logic                     s2_valid_i,
  output logic                     s2_ready_o,
  input  logic signed [HIST_W-1:0] s2_x_i,
  input  dift_ctl_t                s2_ctl_i,
  output logic                     s3_valid_o,
  input  logic                     s3_ready_i,
  output logic signed [HIST_W-1:0] s3_y_o,
  output logic                     s3_clr_flag_o
);

  localparam int unsigned SPLIT = 24;
  localparam int unsigned CM_W  = COEF_W + HIST_W - SPLIT + 3;
  localparam int unsigned ACC_W = CM_W + 3;
  localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

  // Exact floor(c * y / 2^22), with y split into a signed high part and an unsigned low part.
  function automatic logic signed [CM_W-1:0] coef_mul(input logic signed [COEF_W-1:0] c,
                                                      input logic signed [HIST_W-1:0] y);
    logic signed [HIST_W-SPLIT-1:0]       hi;
    logic signed [SPLIT:0]                lo;
    logic signed [COEF_W+HIST_W-SPLIT-1:0] p_hi;
    logic signed [COEF_W+SPLIT:0]         p_lo;
    hi   = y[HIST_W-1:SPLIT];
    lo   = {1'b0, y[SPLIT-1:0]};
    p_hi = c * hi;
    p_lo = c * lo;
    return (CM_W'(p_hi) <<< (SPLIT - COEF_FRAC)) + CM_W'(p_lo >>> COEF_FRAC);
  endfunction

  logic signed [HIST_W-1:0] ih1_q, ih2_q, oh1_q, oh2_q;
  logic signed [HIST_W-1:0] ih1_d, ih2_d, oh1_d, oh2_d;
  logic signed [HIST_W-1:0] ih1_u, ih2_u, oh1_u, oh2_u;
  logic signed [CM_W-1:0]   cm_a, cm_b;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-HIST_W:0]    top;
  logic signed [HIST_W-1:0] y;
  logic                     s3_valid_q, s3_clr_flag_q, adv;
  logic signed [HIST_W-1:0] s3_y_q;

  assign ih1_u = s2_ctl_i.clr_hist ? '0 : ih1_q;
  assign ih2_u = s2_ctl_i.clr_hist ? '0 : ih2_q;
  assign oh1_u = s2_ctl_i.clr_hist ? '0 : oh1_q;
  assign oh2_u = s2_ctl_i.clr_hist ? '0 : oh2_q;

  assign cm_a = coef_mul(coef_a_i, oh1_u);
  assign cm_b = coef_mul(coef_b_i, oh2_u);
  assign acc  = ACC_W'(s2_x_i) - ACC_W'(ih1_u) + ACC_W'(cm_a) +
                (filter_mode_i ? ACC_W'(cm_b) : '0);
  assign top  = acc[ACC_W-1:HIST_W-1];

  always_comb begin
    if ((&top) || !(|top)) begin
      y = acc[HIST_W-1:0];
    end else if (acc[ACC_W-1]) begin
      y = HIST_MIN;
    end else begin
      y = HIST_MAX;
    end
  end

  always_comb begin
    if (filter_mode_i) begin
      ih1_d = ih2_u;
      ih2_d = s2_x_i;
      oh1_d = oh2_u;
      oh2_d = y;
    end else begin
      ih1_d = s2_x_i;
      ih2_d = ih2_u;
      oh1_d = y;
      oh2_d = oh2_u;
    end
  end

  assign s2_ready_o = !s3_valid_q || s3_ready_i;
  assign adv        = s2_valid_i && s2_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ih1_q      <= '0;
      ih2_q      <= '0;
      oh1_q      <= '0;
      oh2_q      <= '0;
      s3_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        ih1_q <= ih1_d;
        ih2_q <= ih2_d;
        oh1_q <= oh1_d;
        oh2_q <= oh2_d;
      end
      if (s2_ready_o) begin
        s3_valid_q <= s2_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_y_q        <= y;
      s3_clr_flag_q <= s2_ctl_i.clr_flag;
    end
  end

  assign s3_valid_o    = s3_valid_q;
  assign s3_y_o        = s3_y_q;
  assign s3_clr_flag_o = s3_clr_flag_q;

  `DIFT_ASSERT_NEXT(a_output_in_history, clk_i, rst_ni, adv, (oh1_q == s3_y_q) || (oh2_q == s3_y_q), "new output missing from history")

endmodule

// ===== sv/dift_out.sv =====
// Output stage: truncates and clamps the filter output, updates the sticky threshold flag.
// Depends on dift_pkg.
module dift_out import dift_pkg::*; #(
  parameter int unsigned HISTORY_FRAC_BITS = DEF_HISTORY_FRAC_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [THRESH_W-1:0]        threshold_i,
  input  logic                       s3_valid_i,
  output logic                       s3_ready_o,
  input  logic signed [HIST_W-1:0]   s3_y_i,
  input  logic                       s3_clr_flag_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       threshold_exceeded_o
);

  logic [HIST_W-1:0]          mag_full, shifted;
  logic [MAG_W-1:0]           mag;
  logic signed [SAMPLE_W-1:0] r;
  logic                       hit, adv;
  logic                       out_valid_q, flag_q;
  logic signed [SAMPLE_W-1:0] sample_q;

  assign mag_full = s3_y_i[HIST_W-1] ? (~s3_y_i + HIST_W'(1)) : s3_y_i;
  assign shifted  = mag_full >> HISTORY_FRAC_BITS;
  assign mag      = (|shifted[HIST_W-1:MAG_W]) ? OUT_MAG_MAX : shifted[MAG_W-1:0];
  assign r        = s3_y_i[HIST_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign hit      = {1'b0, mag} >= threshold_i;

  assign s3_ready_o = !out_valid_q || out_ready_i;
  assign adv        = s3_valid_i && s3_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      flag_q      <= 1'b0;
    end else begin
      if (s3_ready_o) begin
        out_valid_q <= s3_valid_i;
      end
      if (adv) begin
        flag_q <= (flag_q && !s3_clr_flag_i) || hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sample_q <= r;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign sample_out_o         = sample_q;
  assign threshold_exceeded_o = flag_q;

endmodule

// ===== tb/decimating_iir_filter_with_threshold_unit_tb.sv =====
// Self-checking testbench for the decimating IIR filter unit with its threshold flag.
// Depends on dift_pkg, dift_in_if, dift_out_if and decimating_iir_filter_with_threshold_unit;
// a cycle-free predictor of the filter arithmetic checks every output transaction.
`timescale 1ns / 1ps

module decimating_iir_filter_with_threshold_unit_tb;
  import dift_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1300;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_PRINTED    = 100;

  typedef logic signed [95:0] wide_t;

  localparam wide_t HIST_MAX_W = 96'sh7FFF_FFFF_FFFF;
  localparam wide_t HIST_MIN_W = -HIST_MAX_W - 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       flag;
  } filt_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dift_in_if  in_if ();
  dift_out_if out_if ();

  decimating_iir_filter_with_threshold_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Register mirror.
  logic                     cfg_mode   = RST_FILTER_MODE;
  logic [FACTOR_W-1:0]      cfg_factor = RST_DECIMATION;
  logic [GAIN_W-1:0]        cfg_gain   = RST_GAIN;
  logic signed [COEF_W-1:0] cfg_coef_a = RST_COEF;
  logic signed [COEF_W-1:0] cfg_coef_b = RST_COEF;
  logic [THRESH_W-1:0]      cfg_thresh = RST_THRESHOLD;

  // Predicted filter state.
  logic signed [22:0]       group_acc = '0;
  logic [FACTOR_W-1:0]      group_cnt = '0;
  logic signed [HIST_W-1:0] in_hist  [3] = '{default: '0};
  logic signed [HIST_W-1:0] out_hist [3] = '{default: '0};
  logic                     flag_state = 1'b0;

  filt_result_t pending_outputs[$];

  int unsigned error_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned idle_cycles   = 0;
  bit          src_burst     = 1'b0;
  bit          snk_burst     = 1'b0;
  bit          sink_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  function automatic logic signed [HIST_W-1:0] sat48(input wide_t v);
    if (v > HIST_MAX_W) return HIST_MAX_W[HIST_W-1:0];
    if (v < HIST_MIN_W) return HIST_MIN_W[HIST_W-1:0];
    return v[HIST_W-1:0];
  endfunction

  function automatic wide_t coef_term(input logic signed [COEF_W-1:0] c,
                                      input logic signed [HIST_W-1:0] h);
    wide_t cw;
    wide_t hw;
    cw = wide_t'(c);
    hw = wide_t'(h);
    return (cw * hw) >>> COEF_FRAC;
  endfunction

  function automatic logic [FACTOR_W-1:0] group_len();
    if (cfg_factor == '0) return FACTOR_W'(1);
    if (cfg_factor > FACTOR_W'(DEF_MAX_DECIMATION)) return FACTOR_W'(DEF_MAX_DECIMATION);
    return cfg_factor;
  endfunction

  // Advances the predicted state by one input transaction and queues the output it yields.
  task automatic filter_sample(input logic signed [SAMPLE_W-1:0] smp, input logic bstart,
                               input logic clr);
    wide_t                    acc;
    wide_t                    gain_w;
    wide_t                    yw;
    wide_t                    mag_w;
    logic signed [HIST_W-1:0] x48;
    logic signed [HIST_W-1:0] y48;
    logic [MAG_W-1:0]         mag;
    filt_result_t             res;
    if (bstart) begin
      flag_state = 1'b0;
      group_acc = '0;
      group_cnt = '0;
    end
    if (clr) begin
      in_hist = '{default: '0};
      out_hist = '{default: '0};
    end
    group_acc = group_acc + 23'(smp);
    group_cnt = group_cnt + FACTOR_W'(1);
    if (group_cnt < group_len()) return;

    acc = wide_t'(group_acc);
    gain_w = {68'b0, cfg_gain};
    x48 = sat48((acc * gain_w) >>> (GAIN_FRAC - DEF_HISTORY_FRAC_BITS));
    group_acc = '0;
    group_cnt = '0;

    if (cfg_mode == 1'b0) begin
      in_hist[0] = in_hist[1];
      in_hist[1] = x48;
      out_hist[0] = out_hist[1];
      yw = wide_t'(in_hist[1]);
      yw = yw - wide_t'(in_hist[0]) + coef_term(cfg_coef_a, out_hist[0]);
      y48 = sat48(yw);
      out_hist[1] = y48;
    end else begin
      in_hist[0] = in_hist[1];
      in_hist[1] = in_hist[2];
      in_hist[2] = x48;
      out_hist[0] = out_hist[1];
      out_hist[1] = out_hist[2];
      yw = wide_t'(in_hist[2]);
      yw = yw - wide_t'(in_hist[0]) + coef_term(cfg_coef_a, out_hist[0])
           + coef_term(cfg_coef_b, out_hist[1]);
      y48 = sat48(yw);
      out_hist[2] = y48;
    end

    mag_w = wide_t'(y48);
    if (mag_w < 0) mag_w = -mag_w;
    mag_w = mag_w >>> DEF_HISTORY_FRAC_BITS;
    mag = (mag_w > wide_t'(OUT_MAG_MAX)) ? OUT_MAG_MAX : mag_w[MAG_W-1:0];
    if ({1'b0, mag} >= cfg_thresh) flag_state = 1'b1;

    res.smp = {1'b0, mag};
    if (y48 < 0) res.smp = -res.smp;
    res.flag = flag_state;
    pending_outputs.push_back(res);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      filter_sample(in_if.sample_in, in_if.buffer_start, in_if.clear_history);
    end
  end

  always @(posedge clk) begin : check_results
    filt_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_outputs.size() == 0) begin
        report_error($sformatf("output %0d: unexpected sample_out %0d", results_seen,
                               out_if.sample_out));
      end else begin
        exp_r = pending_outputs.pop_front();
        if (out_if.sample_out !== exp_r.smp) begin
          report_error($sformatf("output %0d: sample_out %0d, predicted %0d", results_seen,
                                 out_if.sample_out, exp_r.smp));
        end
        if (out_if.threshold_exceeded !== exp_r.flag) begin
          report_error($sformatf("output %0d: threshold_exceeded %0b, predicted %0b",
                                 results_seen, out_if.threshold_exceeded, exp_r.flag));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d outputs pending", $time, pending_outputs.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: random stalls per transaction, or one long hold on request.
  initial begin : result_sink
    int unsigned hold;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (sink_hold_req) begin
        hold = LONG_HOLD;
        sink_hold_req = 1'b0;
      end else begin
        hold = snk_burst ? 0 : $urandom_range(0, 15);
      end
      if (hold != 0) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic bstart,
                             input logic clr);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.sample_in <= smp;
    in_if.buffer_start <= bstart;
    in_if.clear_history <= clr;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input dift_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FILTER_MODE:         cfg_mode = data[0];
      REG_DECIMATION_FACTOR:   cfg_factor = data[FACTOR_W-1:0];
      REG_INPUT_GAIN:          cfg_gain = data[GAIN_W-1:0];
      REG_COEF_A:              cfg_coef_a = data[COEF_W-1:0];
      REG_COEF_B:              cfg_coef_b = data[COEF_W-1:0];
      REG_AMPLITUDE_THRESHOLD: cfg_thresh = data[THRESH_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SAMPLE_W'(int'($urandom_range(0, 32)) - 16);
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic randomize_config();
    int                    v;
    logic [CFG_DATA_W-1:0] d;
    write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = CFG_DATA_W'($urandom_range(0, 1) ? 127 : 65);
      2: d = CFG_DATA_W'(64);
      3: d = CFG_DATA_W'($urandom_range(5, 63));
      default: d = CFG_DATA_W'($urandom_range(1, 4));
    endcase
    write_reg(REG_DECIMATION_FACTOR, d);
    case ($urandom_range(0, 5))
      0: d = '0;
      1: d = 28'hFFF_FFFF;
      2, 3: d = CFG_DATA_W'(1048576 + $urandom_range(0, 4096) - 2048);
      default: d = CFG_DATA_W'($urandom_range(0, 1 << 24));
    endcase
    write_reg(REG_INPUT_GAIN, d);
    case ($urandom_range(0, 6))
      0: v = 16777215;
      1: v = -16777216;
      2: v = 0;
      3, 4: v = -int'($urandom_range(3355443, 4152360));
      default: v = int'($urandom_range(0, 8388608)) - 4194304;
    endcase
    write_reg(REG_COEF_A, CFG_DATA_W'(v));
    case ($urandom_range(0, 5))
      0: v = 16777215;
      1: v = -16777216;
      2: v = 0;
      default: v = int'($urandom_range(0, 16777216)) - 8388608;
    endcase
    write_reg(REG_COEF_B, CFG_DATA_W'(v));
    case ($urandom_range(0, 5))
      0: d = '0;
      1: d = CFG_DATA_W'(32767);
      2: d = CFG_DATA_W'($urandom_range(0, 1) ? 32768 : 65535);
      3: d = CFG_DATA_W'($urandom_range(0, 32767));
      default: d = CFG_DATA_W'($urandom_range(0, 3000));
    endcase
    write_reg(REG_AMPLITUDE_THRESHOLD, d);
  endtask

  task automatic test_reset_defaults();
    send_sample(16'sh7FFF, 1'b1, 1'b1);
    send_sample(16'sh8000, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b0);
    send_sample(16'sd0, 1'b0, 1'b1);
    send_sample(16'sd1, 1'b1, 1'b0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_FILTER_MODE, 28'd0);
    write_reg(REG_DECIMATION_FACTOR, 28'd0);
    write_reg(REG_INPUT_GAIN, 28'hFFF_FFFF);
    write_reg(REG_COEF_A, CFG_DATA_W'(16777215));
    write_reg(REG_COEF_B, CFG_DATA_W'(-16777216));
    write_reg(REG_AMPLITUDE_THRESHOLD, 28'd65535);
    send_sample(16'sh7FFF, 1'b1, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_AMPLITUDE_THRESHOLD, 28'd32768);
    send_sample(16'sh7FFF, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_AMPLITUDE_THRESHOLD, 28'd32767);
    send_sample(16'sh8000, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_FILTER_MODE, 28'd1);
    write_reg(REG_DECIMATION_FACTOR, 28'd2);
    write_reg(REG_COEF_A, CFG_DATA_W'(-16777216));
    write_reg(REG_COEF_B, CFG_DATA_W'(16777215));
    send_sample(16'sh7FFF, 1'b0, 1'b0);
    send_sample(16'sh7FFF, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b1);
    send_sample(16'sh7FFF, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_group_boundaries();
    write_reg(REG_FILTER_MODE, 28'd0);
    write_reg(REG_DECIMATION_FACTOR, 28'd4);
    write_reg(REG_INPUT_GAIN, 28'd1048576);
    write_reg(REG_COEF_A, CFG_DATA_W'(2097152));
    write_reg(REG_AMPLITUDE_THRESHOLD, 28'd100);
    send_sample(16'sd1000, 1'b1, 1'b1);
    send_sample(-16'sd2000, 1'b0, 1'b0);
    send_sample(16'sd3000, 1'b0, 1'b0);
    wait_idle();
    // Three samples already pending, so the next one closes the group.
    write_reg(REG_DECIMATION_FACTOR, 28'd2);
    send_sample(16'sd500, 1'b0, 1'b0);
    wait_idle();
    // Band-pass picks up the high-pass histories as they stand.
    write_reg(REG_FILTER_MODE, 28'd1);
    write_reg(REG_DECIMATION_FACTOR, 28'd3);
    send_sample(16'sd7000, 1'b0, 1'b0);
    send_sample(16'sd7000, 1'b0, 1'b0);
    send_sample(-16'sd50, 1'b1, 1'b0);
    send_sample(-16'sd60, 1'b0, 1'b0);
    send_sample(-16'sd70, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_output_stall();
    write_reg(REG_FILTER_MODE, 28'd0);
    write_reg(REG_DECIMATION_FACTOR, 28'd1);
    src_burst = 1'b1;
    snk_burst = 1'b0;
    sink_hold_req = 1'b1;
    repeat (48) send_sample(rand_sample(), 1'b0, 1'b0);
    src_burst = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_buffers();
    int unsigned target;
    int unsigned blen;
    int unsigned grp;
    int unsigned i;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      randomize_config();
      src_burst = ($urandom_range(0, 3) == 0);
      snk_burst = ($urandom_range(0, 3) == 0);
      grp = int'(group_len());
      repeat ($urandom_range(1, 3)) begin
        blen = grp * ((grp > 8) ? $urandom_range(1, 2) : $urandom_range(1, 8))
               + $urandom_range(0, 3);
        for (i = 0; i < blen; i++) begin
          if (i == 0) begin
            send_sample(rand_sample(), 1'b1, $urandom_range(0, 2) == 0);
          end else begin
            send_sample(rand_sample(), $urandom_range(0, 49) == 0, $urandom_range(0, 59) == 0);
          end
        end
      end
      wait_idle();
    end
    src_burst = 1'b0;
    snk_burst = 1'b0;
  endtask

  initial begin : run_tests
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.sample_in = '0;
    in_if.buffer_start = 1'b0;
    in_if.clear_history = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_group_boundaries();
    test_output_stall();
    test_random_buffers();
    wait_idle();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
